[hdl/eda_pkg.sv]
package eda_pkg;

  localparam int SUM_W      = 43;
  localparam int DIST_W     = 22;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;
  localparam int RAD_W      = 2 * DIST_W;
  localparam int REM_W      = DIST_W + 4;
  localparam int ROOT_STEPS = DIST_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_DONE
  } eda_state_t;

  typedef struct packed {
    logic load_in;
    logic square;
    logic accum;
    logic root_init;
    logic root_step;
    logic out_load;
  } eda_cmd_t;

  typedef struct packed {
    logic last_in;
    logic root_done;
    logic out_busy;
  } eda_sts_t;

endpackage

[hdl/eda_ctrl.sv]
module eda_ctrl
  import eda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  eda_sts_t sts,
  output eda_cmd_t cmd
);

  eda_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = sts.last_in ? ST_ROOT_INIT : ST_IDLE;
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/eda_dpath.sv]
module eda_dpath
  import eda_pkg::*;
#(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  eda_cmd_t             cmd,
  output eda_sts_t             sts,
  input  logic [ELEM_BITS-1:0] in_a,
  input  logic [ELEM_BITS-1:0] in_b,
  input  logic                 in_last,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [DIST_W-1:0]    out_dist,
  output logic                 out_ovf
);

  localparam int SQ_W  = 2 * ELEM_BITS;
  localparam int ACC_W = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic signed [ELEM_BITS-1:0] a_r, b_r;
  logic                        last_r;
  logic        [SQ_W-1:0]      sq;
  logic        [SUM_W-1:0]     sum;
  logic        [CNT_W-1:0]     cnt;
  logic                        sat;
  logic        [RAD_W-1:0]     rad;
  logic        [REM_W-1:0]     rem;
  logic        [DIST_W-1:0]    root;
  logic        [STEP_W-1:0]    step;
  logic                        ovf_hold;

  logic signed [ELEM_BITS:0]   diff;
  logic        [ELEM_BITS-1:0] mag;
  logic        [ACC_W-1:0]     wide;
  logic        [REM_W-1:0]     rem_sh;
  logic        [REM_W-1:0]     trial;

  assign diff   = $signed({a_r[ELEM_BITS-1], a_r}) - $signed({b_r[ELEM_BITS-1], b_r});
  assign mag    = diff[ELEM_BITS] ? ELEM_BITS'(-diff) : ELEM_BITS'(diff);
  assign wide   = ACC_W'(sum) + ACC_W'(sq);
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = REM_W'({root, 2'b01});

  assign sts.last_in   = last_r;
  assign sts.root_done = (step == STEP_W'(ROOT_STEPS - 1));
  assign sts.out_busy  = out_valid && !out_ready;

  // input beat and squared difference
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r    <= in_a;
      b_r    <= in_b;
      last_r <= in_last;
    end
    if (cmd.square) begin
      sq <= mag * mag;
    end
  end

  // running sum with saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      cnt <= '0;
      sat <= 1'b0;
    end else if (cmd.root_init) begin
      sum <= '0;
      cnt <= '0;
      sat <= 1'b0;
    end else if (cmd.accum) begin
      if (cnt >= CNT_W'(MAX_DIM)) begin
        sat <= 1'b1;
        sum <= '1;
      end else begin
        cnt <= cnt + CNT_W'(1);
        if (wide[ACC_W-1:SUM_W] != '0) begin
          sum <= '1;
          sat <= 1'b1;
        end else begin
          sum <= wide[SUM_W-1:0];
        end
      end
    end
  end

  // digit-by-digit square root, one result bit per step
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad      <= RAD_W'(sum);
      rem      <= '0;
      root     <= '0;
      step     <= '0;
      ovf_hold <= sat;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      step <= step + STEP_W'(1);
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[DIST_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[DIST_W-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dist <= root;
      out_ovf  <= ovf_hold;
    end
  end

endmodule

[hdl/euclidean_distance_accumulator.sv]
// a pair without tlast passes the square and add states before the next beat is taken
// a pair with tlast then passes root setup, 22 root steps and the output load, and the
// output load waits while an earlier result is still stalled on the output
// one pair is in work at a time: a new pair is taken only when the control is back in idle
// the output register lets the next vector stream in while a result waits
// reset: synchronous, clears the sum, element count, overflow flag and output valid
module euclidean_distance_accumulator
  import eda_pkg::*;
#(
  parameter int MAX_DIM   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((2 * ELEM_BITS + 7) / 8) * 8-1:0] s_tdata,  // elem_a, elem_b
  input  logic                                    s_tlast,  // last
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [OUT_DATA_W-1:0]                   m_tdata,  // distance
  output logic                                    m_tuser   // overflow
);

  eda_cmd_t          cmd;
  eda_sts_t          sts;
  logic [DIST_W-1:0] root_dist;

  eda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eda_dpath #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_a      (s_tdata[ELEM_BITS-1:0]),
    .in_b      (s_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .in_last   (s_tlast),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_dist  (root_dist),
    .out_ovf   (m_tuser)
  );

  assign m_tdata = OUT_DATA_W'(root_dist);

endmodule

[hdl/eda_checker.sv]
module eda_checker
  import eda_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tlast,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one pair in work at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // a result does not appear as soon as a last beat is taken; the root pass comes first
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !$rose(m_tvalid))
    else $error("result too early");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:DIST_W] == '0)
    else $error("distance pad bits set");

endmodule

bind euclidean_distance_accumulator eda_checker u_eda_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[dv/testbench.sv]
module testbench;
  import eda_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int ELEM_BITS = 16;
  localparam int IN_DATA_W = ((2 * ELEM_BITS + 7) / 8) * 8;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [SUM_W:0] SUM_MAX = (44'd1 << SUM_W) - 44'd1;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // elem_a, elem_b
  logic                  s_tlast;   // last
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;   // distance
  logic                  m_tuser;   // overflow

  // predictor state
  logic [SUM_W-1:0] acc_sum = '0;
  int unsigned      pair_cnt = 0;
  logic             acc_sat = 1'b0;

  dist_result_t dist_q[$];
  dist_result_t want;
  int           fails = 0;
  int           idle_cycles = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  sink_stall_pct = 0;

  euclidean_distance_accumulator #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [DIST_W-1:0] floor_root(input logic [SUM_W-1:0] x);
    logic [DIST_W-1:0] r;
    logic [SUM_W:0]    t;
    r = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      r[i] = 1'b1;
      t = r * r;
      if (t > x) r[i] = 1'b0;
    end
    return r;
  endfunction

  function automatic void fold_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                    input logic lst);
    logic signed [17:0] d;
    logic [16:0]        mag;
    logic [33:0]        sq;
    logic [SUM_W:0]     total;
    dist_result_t       res;
    if (pair_cnt >= MAX_DIM) begin
      acc_sat = 1'b1;
      acc_sum = '1;
    end else begin
      d = a - b;
      mag = d[17] ? 17'(-d) : 17'(d);
      sq = mag * mag;
      total = acc_sum + sq;
      if (total > SUM_MAX) begin
        acc_sum = '1;
        acc_sat = 1'b1;
      end else begin
        acc_sum = total[SUM_W-1:0];
      end
      pair_cnt++;
    end
    if (lst) begin
      res.distance = floor_root(acc_sum);
      res.overflow = acc_sat;
      dist_q = {dist_q, res};
      acc_sum = '0;
      pair_cnt = 0;
      acc_sat = 1'b0;
    end
  endfunction

  function automatic logic signed [15:0] pick_elem();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = 16'h0000;
      3, 4: v = 16'($urandom_range(511)) - 16'd256;
      default: v = 16'($urandom);
    endcase
    return $signed(v);
  endfunction

  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    fold_pair(a, b, lst);
  endtask

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++) send_pair(pick_elem(), pick_elem(), i == len - 1);
  endtask

  task automatic set_idle(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  task automatic test_directed();
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(16'sd256, 16'sd0, 1'b1);
    send_pair(-16'sd1, 16'sd0, 1'b1);
    // no last mark keeps accumulating
    for (int i = 0; i < 4; i++) send_pair(16'sd32767, -16'sd32768, i == 3);
    send_pair(16'sd768, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1024, 1'b1);
    send_pair(-16'sd32768, 16'sd0, 1'b0);
    send_pair(16'sd0, -16'sd32768, 1'b0);
    send_pair(16'sd12345, -16'sd6789, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
  endtask

  task automatic test_random_vectors(input int n_pairs);
    int sent;
    int len;
    sent = 0;
    while (sent < n_pairs) begin
      case ($urandom_range(19))
        0: len = $urandom_range(41, 128);
        1, 2, 3, 4, 5: len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      send_vector(len);
      sent += len;
    end
  endtask

  // a pair past the maximum count saturates the sum, flag clears on the next vector
  task automatic test_too_many();
    send_vector(MAX_DIM + 1);
    send_vector(2);
    send_pair(16'sd512, 16'sd0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (dist_q.size() == 0) begin
        $error("unexpected result beat: distance %0d overflow %0b",
               m_tdata[DIST_W-1:0], m_tuser);
        fails++;
      end else begin
        want = dist_q.pop_front();
        if (m_tdata[DIST_W-1:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_tdata[DIST_W-1:0]);
          fails++;
        end
        if (m_tuser !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, m_tuser);
          fails++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_idle(25, 57);
    test_directed();
    test_random_vectors(125);

    set_idle(57, 25);
    test_random_vectors(125);
    test_too_many();

    set_idle(0, 0);
    test_random_vectors(125);
    test_directed();

    s_tvalid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
